// ----- design/rfsc_pkg.sv -----
package rfsc_pkg;

  // Command codes of an input item
  typedef enum logic [2:0] {
    CMD_RX_BYTE  = 3'd0,
    CMD_TX_READY = 3'd1,
    CMD_TICK     = 3'd2,
    CMD_START_TX = 3'd3,
    CMD_WRITE_TX = 3'd4,
    CMD_READ_RX  = 3'd5,
    CMD_REARM    = 3'd6
  } cmd_e;

  // Link states as seen on link_state
  typedef enum logic [1:0] {
    LINK_WAIT = 2'd0,
    LINK_RECV = 2'd1,
    LINK_DONE = 2'd2,
    LINK_SEND = 2'd3
  } link_mode_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 1;
  localparam logic [CfgIdxW-1:0] CFG_GAP_TICKS        = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_TURNAROUND_TICKS = 1'b1;

  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgDataW-1:0] GAP_TICKS_RST        = 16'h0038;
  localparam logic [CfgDataW-1:0] TURNAROUND_TICKS_RST = 16'h000A;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic [7:0] entry_index;
    logic [7:0] send_length;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [7:0] read_data;
    logic [1:0] link_state;
    logic [7:0] frame_length;
    logic       frame_done;
    logic       driver_enable;
    logic       activity_led;
  } out_item_t;

  // Result fields known at accept time; buffer data joins them in the cycle after acceptance
  typedef struct packed {
    logic       tx_valid;
    logic       is_read;
    logic [1:0] link_state;
    logic [7:0] frame_length;
    logic       frame_done;
    logic       driver_enable;
    logic       activity_led;
  } rfsc_meta_t;

endpackage

// ----- design/rs485_frame_silence_controller.sv -----
// Each accepted item passes through the s1 stage register, where buffer read data joins it, into the output register.
// Throughput: one item per cycle while the output is not stalled; buffer reads use one registered port per buffer.
// Both buffers are read-modify-write free: each item does at most one read or one write each.
// Reset (rst_ni low, asynchronous): link waits to receive, timer, positions and flags clear,
// gap_ticks returns to 0x38 and turnaround_ticks to 0x0A; buffer contents are not cleared.
module rs485_frame_silence_controller import rfsc_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = 256,
  parameter int unsigned TIMER_WIDTH  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AddrW = $clog2(BUFFER_DEPTH);

  logic [CfgDataW-1:0] gap_ticks_q;
  logic [CfgDataW-1:0] turn_ticks_q;

  logic             acc;
  logic             rx_we, rx_re, tx_we, tx_re;
  logic [AddrW-1:0] rx_waddr, rx_raddr, tx_waddr, tx_raddr;
  logic [7:0]       rx_wdata, tx_wdata, rx_rdata, tx_rdata;
  rfsc_meta_t       meta;

  assign acc = in_valid_i && !in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_ticks_q  <= GAP_TICKS_RST;
      turn_ticks_q <= TURNAROUND_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GAP_TICKS:        gap_ticks_q  <= cfg_data_i;
        CFG_TURNAROUND_TICKS: turn_ticks_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  rfsc_ctrl #(
    .BufferDepth (BUFFER_DEPTH),
    .AddrW       (AddrW),
    .TimerW      (TIMER_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .item_i       (in_item_i),
    .gap_ticks_i  (gap_ticks_q),
    .turn_ticks_i (turn_ticks_q),
    .rx_we_o      (rx_we),
    .rx_waddr_o   (rx_waddr),
    .rx_wdata_o   (rx_wdata),
    .rx_re_o      (rx_re),
    .rx_raddr_o   (rx_raddr),
    .tx_we_o      (tx_we),
    .tx_waddr_o   (tx_waddr),
    .tx_wdata_o   (tx_wdata),
    .tx_re_o      (tx_re),
    .tx_raddr_o   (tx_raddr),
    .meta_o       (meta)
  );

  // receive buffer
  rfsc_store #(
    .Depth (BUFFER_DEPTH),
    .AddrW (AddrW)
  ) u_rx_store (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_waddr),
    .wdata_i (rx_wdata),
    .re_i    (rx_re),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  // transmit buffer
  rfsc_store #(
    .Depth (BUFFER_DEPTH),
    .AddrW (AddrW)
  ) u_tx_store (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_waddr),
    .wdata_i (tx_wdata),
    .re_i    (tx_re),
    .raddr_i (tx_raddr),
    .rdata_o (tx_rdata)
  );

  rfsc_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .meta_i      (meta),
    .rx_rdata_i  (rx_rdata),
    .tx_rdata_i  (tx_rdata),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- design/rfsc_store.sv -----
module rfsc_store import rfsc_pkg::*; #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port, held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/rfsc_ctrl.sv -----
module rfsc_ctrl import rfsc_pkg::*; #(
  parameter int unsigned BufferDepth = 256,
  parameter int unsigned AddrW       = 8,
  parameter int unsigned TimerW      = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  in_item_t            item_i,
  input  logic [CfgDataW-1:0] gap_ticks_i,
  input  logic [CfgDataW-1:0] turn_ticks_i,
  output logic                rx_we_o,
  output logic [AddrW-1:0]    rx_waddr_o,
  output logic [7:0]          rx_wdata_o,
  output logic                rx_re_o,
  output logic [AddrW-1:0]    rx_raddr_o,
  output logic                tx_we_o,
  output logic [AddrW-1:0]    tx_waddr_o,
  output logic [7:0]          tx_wdata_o,
  output logic                tx_re_o,
  output logic [AddrW-1:0]    tx_raddr_o,
  output rfsc_meta_t          meta_o
);

  localparam int unsigned CmpW    = (AddrW > 8) ? AddrW : 8;
  localparam int unsigned RldW    = (TimerW > CfgDataW) ? TimerW : CfgDataW;
  localparam int unsigned MaxQuot = 255 / BufferDepth;
  localparam logic [AddrW-1:0] PosLast = AddrW'(BufferDepth - 1);

  link_mode_e        mode_q, mode_d;
  logic [AddrW-1:0]  rx_pos_q, rx_pos_d;
  logic [AddrW-1:0]  tx_pos_q, tx_pos_d;
  logic [7:0]        send_cnt_q, send_cnt_d;
  logic [AddrW-1:0]  closed_len_q, closed_len_d;
  logic [TimerW-1:0] sil_cnt_q, sil_cnt_d;
  logic              sil_run_q, sil_run_d;
  logic              reload_turn_q, reload_turn_d;
  logic              tx_on_q, tx_on_d;
  logic              drv_on_q, drv_on_d;
  logic              led_on_q, led_on_d;

  logic [7:0]        idx_wrap;
  logic [AddrW-1:0]  idx;
  logic [RldW-1:0]   reload_ext;
  logic [TimerW-1:0] reload_val;
  logic [CmpW-1:0]   closed_ext;
  logic              tx_valid;
  logic              frame_done;
  logic              is_read;

  // entry index modulo buffer depth: compare against each multiple of the depth
  always_comb begin
    idx_wrap = item_i.entry_index;
    for (int k = 1; k <= MaxQuot; k++) begin
      if (item_i.entry_index >= 8'(k * BufferDepth)) begin
        idx_wrap = item_i.entry_index - 8'(k * BufferDepth);
      end
    end
  end
  assign idx = AddrW'(idx_wrap);

  // next state of the link, positions, timer and flags, and the buffer strobes
  always_comb begin
    mode_d        = mode_q;
    rx_pos_d      = rx_pos_q;
    tx_pos_d      = tx_pos_q;
    send_cnt_d    = send_cnt_q;
    closed_len_d  = closed_len_q;
    sil_cnt_d     = sil_cnt_q;
    sil_run_d     = sil_run_q;
    reload_turn_d = reload_turn_q;
    tx_on_d       = tx_on_q;
    drv_on_d      = drv_on_q;
    led_on_d      = led_on_q;
    tx_valid      = 1'b0;
    frame_done    = 1'b0;
    is_read       = 1'b0;
    rx_we_o       = 1'b0;
    rx_re_o       = 1'b0;
    tx_we_o       = 1'b0;
    tx_re_o       = 1'b0;
    reload_ext    = '0;
    reload_val    = '0;

    if (acc_i) begin
      case (cmd_e'(item_i.cmd))
        CMD_RX_BYTE: begin
          led_on_d = 1'b1;
          rx_we_o  = 1'b1;
          rx_pos_d = (rx_pos_q == PosLast) ? '0 : rx_pos_q + 1'b1;
          if (mode_q == LINK_WAIT) begin
            mode_d        = LINK_RECV;
            reload_turn_d = 1'b0;
          end
          reload_ext = RldW'(reload_turn_d ? turn_ticks_i : gap_ticks_i);
          reload_val = reload_ext[TimerW-1:0];
          sil_cnt_d  = reload_val;
          sil_run_d  = 1'b1;
        end
        CMD_TX_READY: begin
          if (tx_on_q) begin
            led_on_d = 1'b1;
            if (CmpW'(tx_pos_q) == CmpW'(send_cnt_q)) begin
              // last byte gone: run the turnaround time
              reload_turn_d = 1'b1;
              reload_ext    = RldW'(turn_ticks_i);
              reload_val    = reload_ext[TimerW-1:0];
              sil_cnt_d     = reload_val;
              sil_run_d     = 1'b1;
              tx_on_d       = 1'b0;
            end else begin
              tx_valid = 1'b1;
              tx_re_o  = 1'b1;
              tx_pos_d = (tx_pos_q == PosLast) ? '0 : tx_pos_q + 1'b1;
            end
          end
        end
        CMD_TICK: begin
          if (sil_run_q) begin
            if (sil_cnt_q > TimerW'(1)) begin
              sil_cnt_d = sil_cnt_q - 1'b1;
            end else begin
              sil_cnt_d = '0;
              sil_run_d = 1'b0;
              if (mode_q == LINK_RECV) begin
                mode_d       = LINK_DONE;
                led_on_d     = 1'b0;
                closed_len_d = rx_pos_q;
                rx_pos_d     = '0;
                frame_done   = 1'b1;
              end else if (mode_q == LINK_SEND) begin
                tx_pos_d      = '0;
                mode_d        = LINK_WAIT;
                drv_on_d      = 1'b0;
                reload_turn_d = 1'b0;
                led_on_d      = 1'b0;
              end
            end
          end
        end
        CMD_START_TX: begin
          send_cnt_d = item_i.send_length;
          drv_on_d   = 1'b1;
          tx_on_d    = 1'b1;
          mode_d     = LINK_SEND;
        end
        CMD_WRITE_TX: begin
          tx_we_o = 1'b1;
        end
        CMD_READ_RX: begin
          rx_re_o = 1'b1;
          is_read = 1'b1;
        end
        CMD_REARM: begin
          if (mode_q == LINK_DONE) begin
            mode_d = LINK_WAIT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= LINK_WAIT;
      rx_pos_q      <= '0;
      tx_pos_q      <= '0;
      send_cnt_q    <= '0;
      closed_len_q  <= '0;
      sil_cnt_q     <= '0;
      sil_run_q     <= 1'b0;
      reload_turn_q <= 1'b0;
      tx_on_q       <= 1'b0;
      drv_on_q      <= 1'b0;
      led_on_q      <= 1'b0;
    end else begin
      mode_q        <= mode_d;
      rx_pos_q      <= rx_pos_d;
      tx_pos_q      <= tx_pos_d;
      send_cnt_q    <= send_cnt_d;
      closed_len_q  <= closed_len_d;
      sil_cnt_q     <= sil_cnt_d;
      sil_run_q     <= sil_run_d;
      reload_turn_q <= reload_turn_d;
      tx_on_q       <= tx_on_d;
      drv_on_q      <= drv_on_d;
      led_on_q      <= led_on_d;
    end
  end

  // buffer addresses
  assign rx_waddr_o = rx_pos_q;
  assign rx_wdata_o = item_i.data_byte;
  assign rx_raddr_o = idx;
  assign tx_waddr_o = idx;
  assign tx_wdata_o = item_i.data_byte;
  assign tx_raddr_o = tx_pos_q;

  // status after this item
  assign closed_ext = CmpW'(closed_len_d);

  always_comb begin
    meta_o               = '0;
    meta_o.tx_valid      = tx_valid;
    meta_o.is_read       = is_read;
    meta_o.link_state    = mode_d;
    meta_o.frame_length  = closed_ext[7:0];
    meta_o.frame_done    = frame_done;
    meta_o.driver_enable = drv_on_d;
    meta_o.activity_led  = led_on_d;
  end

endmodule

// ----- design/rfsc_outq.sv -----
module rfsc_outq import rfsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       acc_i,
  input  rfsc_meta_t meta_i,
  input  logic [7:0] rx_rdata_i,
  input  logic [7:0] tx_rdata_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o
);

  logic       s1_valid_q, s1_valid_d;
  rfsc_meta_t s1_meta_q;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_item_q;
  out_item_t  s1_item;
  logic       out_free;
  logic       s1_move;

  // output register empties or is taken this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;

  // join status with the buffer read data
  always_comb begin
    s1_item               = '0;
    s1_item.tx_valid      = s1_meta_q.tx_valid;
    s1_item.tx_byte       = s1_meta_q.tx_valid ? tx_rdata_i : 8'h00;
    s1_item.read_data     = s1_meta_q.is_read ? rx_rdata_i : 8'h00;
    s1_item.link_state    = s1_meta_q.link_state;
    s1_item.frame_length  = s1_meta_q.frame_length;
    s1_item.frame_done    = s1_meta_q.frame_done;
    s1_item.driver_enable = s1_meta_q.driver_enable;
    s1_item.activity_led  = s1_meta_q.activity_led;
  end

  always_comb begin
    s1_valid_d  = acc_i ? 1'b1 : (s1_move ? 1'b0 : s1_valid_q);
    out_valid_d = s1_move ? 1'b1 : (out_free ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_meta_q <= meta_i;
    end
    if (s1_move) begin
      out_item_q <= s1_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
